// ===== rtl/ffsm_pkg.sv =====
package ffsm_pkg;
  localparam int unsigned WordW = 32;
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;
  localparam logic [7:0] ExpMax = 8'hff;

  typedef logic [WordW-1:0] word_t;
endpackage

// ===== rtl/float_fixed_sign_magnitude_converter.sv =====
// Float / sign-magnitude Q15.16 converter.
// Input stream s_axis: tuser carries the mode (0 encode float to fixed,
// 1 decode fixed to float), tdata the 32-bit operand. Output stream m_axis
// carries the 32-bit result in tdata.
// Encode truncates toward zero, keeps the low 15 integer bits, maps NaN and
// infinity to magnitude zero, and sets the sign only for values below zero.
// Decode rounds to nearest-even in single precision; a signed zero gives -0.0.
// Each result is valid in the result register in the cycle after input acceptance.
// Throughput: one item per cycle; the single result register is the only
// storage, and it refills in the same cycle it is taken.
// When the receiver stalls, the result register holds and s_axis_tready
// drops until the result is taken.
// Reset clears the result valid flag; the result data register is not reset.
module float_fixed_sign_magnitude_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] operand
  input  logic                s_axis_tuser,   // [0] mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output ffsm_pkg::word_t     m_axis_tdata    // [31:0] result
);
  import ffsm_pkg::*;

  logic       neg;
  logic [7:0] ex;
  logic [22:0] man;
  logic [23:0] sig;
  logic [8:0] shl;       // left shift amount when ex-134 >= 0
  logic [8:0] shr;       // right shift amount: 134-ex, or 133 when ex == 0
  logic [62:0] shifted;
  logic [30:0] enc_mag;
  logic       enc_sign;
  word_t      enc;

  logic [30:0] mag;
  logic [4:0]  p;
  logic [30:0] norm;     // leading one at bit 30
  logic [23:0] q;
  logic        rnd;
  logic [24:0] qr;
  logic [7:0]  dex;
  word_t       dec;
  word_t       result_next;

  // Encode: value = sig * 2^(ex-150), scaled by 2^16.
  always_comb begin
    neg = s_axis_tdata[31];
    ex  = s_axis_tdata[30:23];
    man = s_axis_tdata[22:0];
    sig = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
    shl = 9'd0;
    shr = 9'd0;
    if (ex == 8'd0) shr = 9'd133;
    else if (ex >= 8'd134) shl = {1'b0, ex} - 9'd134;
    else shr = 9'd134 - {1'b0, ex};
    shifted = 63'd0;
    if (shl != 9'd0) begin
      if (shl < 9'd40) shifted = {39'd0, sig} << shl[5:0];
    end else if (shr < 9'd40) begin
      shifted = {39'd0, sig} >> shr[5:0];
    end
    enc_mag = shifted[30:0];
    enc_sign = neg && ((ex != 8'd0) || (man != 23'd0));
    if (ex == ExpMax) begin
      enc = {neg && (man == 23'd0), 31'd0};
    end else begin
      enc = {enc_sign, enc_mag};
    end
  end

  // Decode: leading-one search, normalize, round to 24 bits.
  // Bits below the dropped part of norm are always zero, so norm[5:0]
  // holds the sticky part of the remainder.
  always_comb begin
    mag = s_axis_tdata[30:0];
    p = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd30 - p);
    q    = norm[30:7];
    rnd  = (p > 5'd23) && norm[6] && ((norm[5:0] != 6'd0) || q[0]);
    qr   = {1'b0, q} + {24'd0, rnd};
    dex  = 8'({3'd0, p} + 8'd111) + {7'd0, qr[24]};
    if (mag == 31'd0) dec = {s_axis_tdata[31], 31'd0};
    else dec = {s_axis_tdata[31], dex, qr[24] ? qr[23:1] : qr[22:0]};
  end

  assign result_next   = (s_axis_tuser == ModeDecode) ? dec : enc;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      m_axis_tdata <= result_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item lost");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ModeEncode &&
    s_axis_tdata[30:23] == ExpMax |=> m_axis_tdata[30:0] == 31'd0)
    else $error("special value gave nonzero magnitude");
endmodule
